@@ rtl/asc_pkg.sv @@
// shared types and constants for the anti-aliased segment coverage block
package asc_pkg;

	localparam int SCREEN_WIDTH  = 1024;
	localparam int SCREEN_HEIGHT = 1024;

	localparam int DIV_STEPS  = 16;
	localparam int SQRT_STEPS = 24;

	localparam logic [2:0] REG_START_X      = 3'd0;
	localparam logic [2:0] REG_START_Y      = 3'd1;
	localparam logic [2:0] REG_END_X        = 3'd2;
	localparam logic [2:0] REG_END_Y        = 3'd3;
	localparam logic [2:0] REG_STROKE_WIDTH = 3'd4;
	localparam logic [2:0] REG_INTENSITY    = 3'd5;

	// segment setup as seen by the datapath
	typedef struct packed {
		logic signed [16:0] sx;
		logic signed [16:0] sy;
		logic signed [17:0] dx;
		logic signed [17:0] dy;
		logic        [35:0] len2;
		logic        [7:0]  sw;
		logic        [7:0]  inten;
		logic               degen;
	} asc_cfg_t;

	// per-pixel payload that rides along the pipeline
	typedef struct packed {
		logic signed [12:0] px;
		logic signed [12:0] py;
		logic        [7:0]  old;
		logic               live;
	} asc_side_t;

endpackage

@@ rtl/asc_cfg.sv @@
// configuration registers and derived segment terms
module asc_cfg
	import asc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [16:0] cfg_data,
	output asc_cfg_t    cfg
);

	logic signed [16:0] start_x_q, start_y_q, end_x_q, end_y_q;
	logic        [7:0]  stroke_width_q, intensity_q;
	logic signed [17:0] dx_q, dy_q;
	logic signed [35:0] dxx_q, dyy_q;
	logic        [35:0] len2_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_x_q      <= '0;
			start_y_q      <= '0;
			end_x_q        <= '0;
			end_y_q        <= '0;
			stroke_width_q <= 8'd16;
			intensity_q    <= 8'd255;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_START_X:      start_x_q      <= cfg_data;
				REG_START_Y:      start_y_q      <= cfg_data;
				REG_END_X:        end_x_q        <= cfg_data;
				REG_END_Y:        end_y_q        <= cfg_data;
				REG_STROKE_WIDTH: stroke_width_q <= cfg_data[7:0];
				REG_INTENSITY:    intensity_q    <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// deltas, their squares and the squared length are registered in turn after a write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dx_q   <= '0;
			dy_q   <= '0;
			dxx_q  <= '0;
			dyy_q  <= '0;
			len2_q <= '0;
		end else begin
			dx_q   <= end_x_q - start_x_q;
			dy_q   <= end_y_q - start_y_q;
			dxx_q  <= dx_q * dx_q;
			dyy_q  <= dy_q * dy_q;
			len2_q <= dxx_q[35:0] + dyy_q[35:0];
		end
	end

	assign cfg.sx    = start_x_q;
	assign cfg.sy    = start_y_q;
	assign cfg.dx    = dx_q;
	assign cfg.dy    = dy_q;
	assign cfg.len2  = len2_q;
	assign cfg.sw    = stroke_width_q;
	assign cfg.inten = intensity_q;
	assign cfg.degen = (dx_q == '0) && (dy_q == '0);

endmodule

@@ rtl/asc_div.sv @@
// pipelined restoring divider for the projection parameter, one quotient bit per stage
module asc_div
	import asc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic [35:0] len2,
	input  logic        in_valid,
	input  asc_side_t   in_side,
	input  logic [35:0] in_num,
	input  logic        in_zero,
	input  logic        in_full,
	output logic        out_valid,
	output asc_side_t   out_side,
	output logic [16:0] out_t
);

	logic        v_s    [DIV_STEPS+1];
	asc_side_t   side_s [DIV_STEPS+1];
	logic [35:0] rem_s  [DIV_STEPS+1];
	logic [15:0] quo_s  [DIV_STEPS+1];
	logic        zero_s [DIV_STEPS+1];
	logic        full_s [DIV_STEPS+1];

	assign v_s[0]    = in_valid;
	assign side_s[0] = in_side;
	assign rem_s[0]  = in_num;
	assign quo_s[0]  = '0;
	assign zero_s[0] = in_zero;
	assign full_s[0] = in_full;

	for (genvar g = 0; g < DIV_STEPS; g++) begin : g_step
		logic [36:0] shifted;
		logic        ge;
		logic [36:0] diff;

		always_comb begin
			shifted = {rem_s[g], 1'b0};
			ge      = shifted >= {1'b0, len2};
			diff    = shifted - {1'b0, len2};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[g+1] <= 1'b0;
			end else if (en) begin
				v_s[g+1] <= v_s[g];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_s[g+1] <= side_s[g];
				rem_s[g+1]  <= ge ? diff[35:0] : shifted[35:0];
				quo_s[g+1]  <= {quo_s[g][14:0], ge};
				zero_s[g+1] <= zero_s[g];
				full_s[g+1] <= full_s[g];
			end
		end
	end

	assign out_valid = v_s[DIV_STEPS];
	assign out_side  = side_s[DIV_STEPS];
	assign out_t     = full_s[DIV_STEPS] ? 17'h10000 :
	                   zero_s[DIV_STEPS] ? 17'h00000 : {1'b0, quo_s[DIV_STEPS]};

endmodule

@@ rtl/asc_sqrt.sv @@
// pipelined digit-by-digit integer square root, one root bit per stage
module asc_sqrt
	import asc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        in_valid,
	input  asc_side_t   in_side,
	input  logic [47:0] in_rad,
	output logic        out_valid,
	output asc_side_t   out_side,
	output logic [23:0] out_root
);

	logic        v_s    [SQRT_STEPS+1];
	asc_side_t   side_s [SQRT_STEPS+1];
	logic [47:0] rad_s  [SQRT_STEPS+1];
	logic [25:0] rem_s  [SQRT_STEPS+1];
	logic [23:0] root_s [SQRT_STEPS+1];

	assign v_s[0]    = in_valid;
	assign side_s[0] = in_side;
	assign rad_s[0]  = in_rad;
	assign rem_s[0]  = '0;
	assign root_s[0] = '0;

	for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_step
		logic [27:0] acc;
		logic [27:0] trial;
		logic        ge;
		logic [27:0] diff;

		always_comb begin
			acc   = {rem_s[g], rad_s[g][47:46]};
			trial = {2'b00, root_s[g], 2'b01};
			ge    = acc >= trial;
			diff  = acc - trial;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[g+1] <= 1'b0;
			end else if (en) begin
				v_s[g+1] <= v_s[g];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_s[g+1] <= side_s[g];
				rad_s[g+1]  <= {rad_s[g][45:0], 2'b00};
				rem_s[g+1]  <= ge ? diff[25:0] : acc[25:0];
				root_s[g+1] <= {root_s[g][22:0], ge};
			end
		end
	end

	assign out_valid = v_s[SQRT_STEPS];
	assign out_side  = side_s[SQRT_STEPS];
	assign out_root  = root_s[SQRT_STEPS];

endmodule

@@ rtl/antialiased_segment_coverage_top.sv @@
// Anti-aliased segment coverage, pixels merged into a framebuffer by maximum.
// Load the segment through the write port (cfg_we, cfg_index, cfg_data):
// 0 start_x, 1 start_y, 2 end_x, 3 end_y (signed Q13.4), 4 stroke_width
// (Q4.4), 5 intensity. Write them only while no pixel is in flight.
// Each pixel word on the s_ stream carries a position and the old
// framebuffer value; each result word on the m_ stream carries the value
// to store and, in m_tuser, whether it must be written.
// Each pixel passes through the 16-stage divider for the projection
// parameter and the 24-stage square root on its way to m_tvalid.
// One pixel is accepted every cycle while the output is taken.
// When the receiver holds m_tready low with a result waiting, the whole
// pipeline freezes and s_tready drops; nothing is lost or repeated.
// Reset loads the register defaults (segment at the origin, width one
// pixel, intensity 255) and empties the pipeline.
module antialiased_segment_coverage_top
	import asc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [16:0] cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // pixel_x[12:0], pixel_y[25:13], old_value[33:26]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // new_value[7:0]
	output logic        m_tuser    // write_enable[0]
);

	asc_cfg_t cfg;
	logic     en;

	asc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// valid bits
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10, v_s11, v_s12;
	logic out_valid_q;
	logic div_valid, sqrt_valid;

	assign en       = !out_valid_q || m_tready;
	assign s_tready = en;

	// stage 1: input word
	logic signed [12:0] px_s1, py_s1;
	logic        [7:0]  old_s1;

	// stage 2: offsets from the start point and visibility
	asc_side_t          side_s2;
	logic signed [17:0] rx_s2, ry_s2;
	logic               on_screen;

	// stage 3..5: projection numerator and classification
	asc_side_t          side_s3, side_s4, side_s5;
	logic signed [35:0] prx_s3, pry_s3;
	logic signed [36:0] n_s4;
	logic               zero_s5, full_s5;
	logic        [35:0] n_s5;

	// after the divider
	asc_side_t          div_side;
	logic        [16:0] div_t;
	asc_side_t          side_s6, side_s7, side_s8, side_s9, side_s10;
	logic        [34:0] mx_s6, my_s6;
	logic        [17:0] adx, ady;
	logic        [35:0] sumx, sumy;
	logic signed [24:0] rx_r_s7, ry_r_s7;
	logic signed [25:0] ex_s8, ey_s8;
	logic signed [51:0] ex2_s9, ey2_s9;
	logic        [47:0] d2_s10;

	// after the square root
	asc_side_t          sqrt_side;
	logic        [23:0] sqrt_root;
	asc_side_t          side_s11, side_s12;
	logic signed [26:0] dd;
	logic signed [28:0] num;
	logic        [10:0] num_s11;
	logic               pos_s11, full_s11, pos_s12, full_s12;
	logic        [18:0] prod_s12;
	logic        [19:0] third;
	logic        [7:0]  cand;
	logic               wr;

	logic [7:0] new_value_q;
	logic [7:0] old_out_q;
	logic       write_enable_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			v_s5        <= 1'b0;
			v_s6        <= 1'b0;
			v_s7        <= 1'b0;
			v_s8        <= 1'b0;
			v_s9        <= 1'b0;
			v_s10       <= 1'b0;
			v_s11       <= 1'b0;
			v_s12       <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			v_s1        <= s_tvalid;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			v_s4        <= v_s3;
			v_s5        <= v_s4;
			v_s6        <= div_valid;
			v_s7        <= v_s6;
			v_s8        <= v_s7;
			v_s9        <= v_s8;
			v_s10       <= v_s9;
			v_s11       <= sqrt_valid;
			v_s12       <= v_s11;
			out_valid_q <= v_s12;
		end
	end

	assign on_screen = (px_s1 >= 13'sd0) && (px_s1 < 13'(SCREEN_WIDTH)) &&
	                   (py_s1 >= 13'sd0) && (py_s1 < 13'(SCREEN_HEIGHT));

	always_ff @(posedge clk) begin
		if (en) begin
			px_s1  <= s_tdata[12:0];
			py_s1  <= s_tdata[25:13];
			old_s1 <= s_tdata[33:26];

			side_s2.px   <= px_s1;
			side_s2.py   <= py_s1;
			side_s2.old  <= old_s1;
			side_s2.live <= on_screen && !cfg.degen;
			rx_s2        <= $signed({px_s1, 4'b0000}) - cfg.sx;
			ry_s2        <= $signed({py_s1, 4'b0000}) - cfg.sy;

			side_s3 <= side_s2;
			prx_s3  <= rx_s2 * cfg.dx;
			pry_s3  <= ry_s2 * cfg.dy;

			side_s4 <= side_s3;
			n_s4    <= prx_s3 + pry_s3;

			side_s5 <= side_s4;
			zero_s5 <= n_s4 <= 37'sd0;
			full_s5 <= n_s4 >= $signed({1'b0, cfg.len2});
			n_s5    <= n_s4[35:0];
		end
	end

	asc_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.len2      (cfg.len2),
		.in_valid  (v_s5),
		.in_side   (side_s5),
		.in_num    (n_s5),
		.in_zero   (zero_s5),
		.in_full   (full_s5),
		.out_valid (div_valid),
		.out_side  (div_side),
		.out_t     (div_t)
	);

	assign adx  = cfg.dx[17] ? 18'(-cfg.dx) : 18'(cfg.dx);
	assign ady  = cfg.dy[17] ? 18'(-cfg.dy) : 18'(cfg.dy);
	assign sumx = {1'b0, mx_s6} + 36'd2048;
	assign sumy = {1'b0, my_s6} + 36'd2048;

	always_ff @(posedge clk) begin
		if (en) begin
			side_s6 <= div_side;
			mx_s6   <= adx * div_t;
			my_s6   <= ady * div_t;

			// closest-point offset rounded half away from zero
			side_s7 <= side_s6;
			rx_r_s7 <= cfg.dx[17] ? -$signed({1'b0, sumx[35:12]}) : $signed({1'b0, sumx[35:12]});
			ry_r_s7 <= cfg.dy[17] ? -$signed({1'b0, sumy[35:12]}) : $signed({1'b0, sumy[35:12]});

			side_s8 <= side_s7;
			ex_s8   <= $signed({side_s7.px, 8'h00}) - $signed({cfg.sx, 4'b0000}) - rx_r_s7;
			ey_s8   <= $signed({side_s7.py, 8'h00}) - $signed({cfg.sy, 4'b0000}) - ry_r_s7;

			side_s9 <= side_s8;
			ex2_s9  <= ex_s8 * ex_s8;
			ey2_s9  <= ey_s8 * ey_s8;

			side_s10 <= side_s9;
			d2_s10   <= ex2_s9[47:0] + ey2_s9[47:0];
		end
	end

	asc_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s10),
		.in_side   (side_s10),
		.in_rad    (d2_s10),
		.out_valid (sqrt_valid),
		.out_side  (sqrt_side),
		.out_root  (sqrt_root)
	);

	// coverage numerator over 1536: 1536 - 5 * (dist - w/2)
	assign dd  = $signed({3'b000, sqrt_root}) - $signed({16'h0000, cfg.sw, 3'b000});
	assign num = 29'sd1536 - 29'sd5 * dd;

	// floor(x / 1536) as floor(floor(x / 512) / 3)
	assign third = prod_s12[18:9] * 11'd683;
	assign cand  = full_s12 ? cfg.inten : (pos_s12 ? third[18:11] : 8'h00);
	assign wr    = side_s12.live && pos_s12 && (cand > side_s12.old);

	always_ff @(posedge clk) begin
		if (en) begin
			side_s11 <= sqrt_side;
			pos_s11  <= num > 29'sd0;
			full_s11 <= num >= 29'sd1536;
			num_s11  <= num[10:0];

			side_s12 <= side_s11;
			pos_s12  <= pos_s11;
			full_s12 <= full_s11;
			prod_s12 <= num_s11 * cfg.inten;

			new_value_q    <= wr ? cand : side_s12.old;
			old_out_q      <= side_s12.old;
			write_enable_q <= wr;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = new_value_q;
	assign m_tuser  = write_enable_q;

	a_write_beats_old: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> new_value_q > old_out_q)
		else $error("written value does not exceed old value");

	a_skip_keeps_old: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> new_value_q == old_out_q)
		else $error("skipped pixel does not return old value");

	a_stall_freezes: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(v_s1) && $stable(v_s12) && $stable(v_s6))
		else $error("pipeline moved during output stall");

	a_reset_empty: assert property (@(posedge clk)
		!arst_n |-> !m_tvalid && !v_s1 && !v_s12)
		else $error("pipeline not empty in reset");

endmodule

@@ sim/antialiased_segment_coverage_top_tb.sv @@
// self-checking testbench for the anti-aliased segment coverage block
module antialiased_segment_coverage_top_tb
	import asc_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [7:0] value;
		logic       wr;
	} pix_result_t;

	typedef struct {
		logic signed [12:0] px;
		logic signed [12:0] py;
		logic        [7:0]  old;
		bit                 has_exp;
		pix_result_t        exp;
	} pix_row_t;

	localparam int LATENCY    = 53;
	localparam int RAND_ITEMS = 1950;
	localparam int MAX_CYCLES = 400000;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [16:0] cfg_data;
	logic        s_tvalid;
	logic        s_tready;
	logic [39:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;
	logic        m_tuser;

	antialiased_segment_coverage_top dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	// shadow copy of the segment setup
	logic signed [16:0] seg_sx, seg_sy, seg_ex, seg_ey;
	logic        [7:0]  seg_width, seg_inten;

	pix_result_t expected_pixels[$];
	int  errors;
	int  cycles;
	bit  stall_hold;
	bit  random_idle;

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > MAX_CYCLES) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

	function automatic longint isqrt_floor(longint unsigned v);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > v) bitv >>= 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	// offset times t (Q1.16) brought to Q.8, halves rounded away from zero
	function automatic longint offset_round(longint delta, longint t);
		longint mag, r;
		mag = (delta < 0) ? -delta : delta;
		r = (mag * t + 2048) >>> 12;
		return (delta < 0) ? -r : r;
	endfunction

	function automatic pix_result_t coverage_merge(logic signed [12:0] px_i,
			logic signed [12:0] py_i, logic [7:0] old);
		longint px, py, sx, sy, dx, dy, rx, ry, n, len2, t, cx, cy, ex, ey, span, d, num;
		longint val;
		pix_result_t r;
		px = px_i; py = py_i;
		sx = seg_sx; sy = seg_sy;
		dx = longint'(seg_ex) - sx;
		dy = longint'(seg_ey) - sy;
		r.value = old;
		r.wr = 1'b0;
		if (px >= 0 && px < SCREEN_WIDTH && py >= 0 && py < SCREEN_HEIGHT
				&& (dx != 0 || dy != 0)) begin
			rx = px * 16 - sx;
			ry = py * 16 - sy;
			n = rx * dx + ry * dy;
			len2 = dx * dx + dy * dy;
			if (n <= 0) t = 0;
			else if (n >= len2) t = 65536;
			else t = (n <<< 16) / len2;
			cx = sx * 16 + offset_round(dx, t);
			cy = sy * 16 + offset_round(dy, t);
			ex = px * 256 - cx;
			ey = py * 256 - cy;
			span = isqrt_floor(ex * ex + ey * ey);
			d = span - longint'(seg_width) * 8;
			num = 1536 - 5 * d;
			if (num > 0) begin
				val = (num >= 1536) ? longint'(seg_inten) : (num * seg_inten) / 1536;
				if (val > old) begin
					r.value = val[7:0];
					r.wr = 1'b1;
				end
			end
		end
		return r;
	endfunction

	task automatic write_reg(logic [2:0] idx, logic [16:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		case (idx)
			REG_START_X:      seg_sx = data;
			REG_START_Y:      seg_sy = data;
			REG_END_X:        seg_ex = data;
			REG_END_Y:        seg_ey = data;
			REG_STROKE_WIDTH: seg_width = data[7:0];
			REG_INTENSITY:    seg_inten = data[7:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic load_segment(logic [16:0] sx, logic [16:0] sy, logic [16:0] ex,
			logic [16:0] ey, logic [7:0] w, logic [7:0] inten);
		write_reg(REG_START_X, sx);
		write_reg(REG_START_Y, sy);
		write_reg(REG_END_X, ex);
		write_reg(REG_END_Y, ey);
		write_reg(REG_STROKE_WIDTH, {9'd0, w});
		write_reg(REG_INTENSITY, {9'd0, inten});
	endtask

	// entered at a falling edge; stops offering and waits for the pipeline to drain
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (expected_pixels.size() != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
		@(negedge clk);
	endtask

	// entered at a falling edge; offers one pixel word until it is taken
	task automatic send_pixel(logic signed [12:0] px, logic signed [12:0] py,
			logic [7:0] old, bit has_exp, pix_result_t exp);
		pix_result_t pred;
		while (random_idle && $urandom_range(99) < 24) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		pred = coverage_merge(px, py, old);
		if (has_exp && pred != exp) begin
			$display("%0t: table row disagrees with predictor: table %h predicted %h",
				$time, exp, pred);
			errors++;
		end
		s_tvalid <= 1'b1;
		s_tdata <= {6'd0, old, py, px};
		expected_pixels.push_back(has_exp ? exp : pred);
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic random_pixel(bit near);
		logic signed [12:0] px, py;
		if (near) begin
			px = 13'($urandom_range(1023));
			py = 13'($urandom_range(1023));
			if ($urandom_range(3) != 0) begin
				px = 13'(((seg_sx + seg_ex) >>> 5) + $signed($urandom_range(40)) - 20);
				py = 13'(((seg_sy + seg_ey) >>> 5) + $signed($urandom_range(40)) - 20);
			end
		end else begin
			px = 13'($urandom);
			py = 13'($urandom);
		end
		send_pixel(px, py, 8'($urandom), 1'b0, '0);
	endtask

	// results are checked at the rising edge
	always @(posedge clk) begin
		pix_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_pixels.size() == 0) begin
				$display("%0t: unexpected result word %h/%b", $time, m_tdata, m_tuser);
				errors++;
			end else begin
				want = expected_pixels.pop_front();
				if (m_tdata !== want.value) begin
					$display("%0t: new_value expected %0d actual %0d", $time, want.value, m_tdata);
					errors++;
				end
				if (m_tuser !== want.wr) begin
					$display("%0t: write_enable expected %b actual %b", $time, want.wr, m_tuser);
					errors++;
				end
			end
		end
	end

	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_hold) m_tready <= 1'b0;
			else if (random_idle) m_tready <= ($urandom_range(99) >= 24);
			else m_tready <= 1'b1;
		end
	end

	pix_row_t directed[$];

	function automatic pix_row_t row(int px, int py, int old, bit has_exp,
			int val, bit wr);
		pix_row_t r;
		r.px = 13'(px); r.py = 13'(py); r.old = 8'(old);
		r.has_exp = has_exp;
		r.exp.value = 8'(val);
		r.exp.wr = wr;
		return r;
	endfunction

	initial begin
		errors = 0;
		stall_hold = 0;
		random_idle = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		seg_sx = '0; seg_sy = '0; seg_ex = '0; seg_ey = '0;
		seg_width = 8'd16; seg_inten = 8'd255;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset segment is degenerate: nothing is ever written
		directed.push_back(row(0, 0, 0, 1, 0, 0));
		directed.push_back(row(5, 5, 200, 1, 200, 0));
		foreach (directed[i])
			send_pixel(directed[i].px, directed[i].py, directed[i].old,
				directed[i].has_exp, directed[i].exp);
		wait_idle();

		// horizontal segment along row 10 from x=0 to x=100
		load_segment(17'd0, 17'd160, 17'd1600, 17'd160, 8'd16, 8'd255);
		directed.delete();
		directed.push_back(row(50, 10, 0, 1, 255, 1));      // on the line
		directed.push_back(row(50, 10, 255, 1, 255, 0));    // not above old
		directed.push_back(row(50, 40, 7, 1, 7, 0));        // far away
		directed.push_back(row(-1, 10, 3, 1, 3, 0));        // off screen left
		directed.push_back(row(1024, 10, 3, 1, 3, 0));      // off screen right
		directed.push_back(row(50, -4096, 9, 1, 9, 0));
		directed.push_back(row(4095, 4095, 9, 1, 9, 0));
		directed.push_back(row(1023, 1023, 0, 1, 0, 0));
		directed.push_back(row(0, 10, 0, 1, 255, 1));       // at start point
		directed.push_back(row(100, 10, 0, 1, 255, 1));     // at end point
		directed.push_back(row(50, 11, 0, 0, 0, 0));
		directed.push_back(row(50, 12, 0, 0, 0, 0));
		directed.push_back(row(105, 10, 0, 0, 0, 0));
		directed.push_back(row(102, 11, 0, 0, 0, 0));
		foreach (directed[i])
			send_pixel(directed[i].px, directed[i].py, directed[i].old,
				directed[i].has_exp, directed[i].exp);
		wait_idle();

		// extremes of the registers
		load_segment(17'h10000, 17'h10000, 17'h0FFFF, 17'h0FFFF, 8'd255, 8'd0);
		send_pixel(13'sd0, 13'sd0, 8'd0, 1'b0, '0);
		send_pixel(13'sd1023, 13'sd1023, 8'd0, 1'b0, '0);
		wait_idle();
		load_segment(17'd0, 17'd0, 17'h0FFFF, 17'h0FFFF, 8'd0, 8'd1);
		send_pixel(13'sd100, 13'sd100, 8'd0, 1'b0, '0);
		send_pixel(13'sd100, 13'sd101, 8'd0, 1'b0, '0);
		wait_idle();

		// random phases with fresh segments
		random_idle = 1;
		for (int ph = 0; ph < 13; ph++) begin
			if (ph % 3 == 0)
				load_segment(17'($urandom), 17'($urandom), 17'($urandom), 17'($urandom),
					8'($urandom), 8'($urandom));
			else
				load_segment(17'($urandom_range(16383)), 17'($urandom_range(16383)),
					17'($urandom_range(16383)), 17'($urandom_range(16383)),
					8'($urandom_range(80)), 8'($urandom));
			if (ph == 4) random_idle = 0;
			if (ph == 6) begin
				fork
					begin
						stall_hold = 1;
						repeat (200) @(posedge clk);
						stall_hold = 0;
					end
				join_none
			end
			for (int i = 0; i < RAND_ITEMS / 13; i++)
				random_pixel($urandom_range(9) != 0);
			random_idle = 1;
			wait_idle();
		end

		wait_idle();
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule

@@ sim.f @@
rtl/asc_pkg.sv
rtl/asc_cfg.sv
rtl/asc_div.sv
rtl/asc_sqrt.sv
rtl/antialiased_segment_coverage_top.sv
sim/antialiased_segment_coverage_top_tb.sv
